FILE: rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// Range-sum segment tree package
// Shared constants, register map and arithmetic unit operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

   // Default sizing of the tree and of the stored values.
   localparam int DEF_MAX_LENGTH  = 1024;
   localparam int DEF_VALUE_WIDTH = 32;

   // Register port geometry: one 32-bit register at byte address 0.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index, taken from the word address bits of paddr.
   localparam logic [CSR_ADDR_W-3:0] REG_USED_LENGTH = '0;

   // Transaction kinds on the request channel.
   localparam logic KIND_SET   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Operations of the shared add/subtract unit.
   typedef enum logic [0:0] {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

endpackage

`default_nettype wire

FILE: rtl/rss_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rss_alu.sv
// ----------------------------------------------------------------------------
// Shared add/subtract unit
// The one arithmetic unit of the tree: difference, path update and sums.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_alu #(
   parameter int WIDTH = 32
) (
   input  rss_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]    a,
   input  logic [WIDTH-1:0]    b,
   output logic [WIDTH-1:0]    y
);

   // Results wrap modulo 2^WIDTH.
   always_comb begin
      case (op)
         rss_pkg::ALU_ADD: y = a + b;
         rss_pkg::ALU_SUB: y = a - b;
         default:          y = a + b;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/range_sum_segment_tree_unit.sv
// ----------------------------------------------------------------------------
// Range-sum segment tree unit
// Point assignment and inclusive range sums over a tree of partial sums,
// walked by a small sequencer around one shared adder and one node RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  kind, position, new_value,
//                                               range_low, range_high
//   rsp_      out        rsp_valid / rsp_stall  range_sum
//   csr       in/out     psel/penable/pready    paddr, pwdata, prdata
//
// After reset the node RAM is swept to zero, one node per cycle, over all
// 2 * 2^clog2(MAX_LENGTH) nodes (2048 at the default size), req_stall high.
// A set reads and writes the node RAM at every level from the leaf to the root.
// A query works through its node reads and level climbs one after another,
// paced by the single RAM read port.
// One transaction is in flight at a time. A finished sum waits in the output
// register under rsp_stall while a set or a query may still be accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module range_sum_segment_tree_unit #(
   parameter int MAX_LENGTH  = rss_pkg::DEF_MAX_LENGTH,
   parameter int VALUE_WIDTH = rss_pkg::DEF_VALUE_WIDTH,
   localparam int POS_W = $clog2(MAX_LENGTH),
   localparam int LEN_W = $clog2(MAX_LENGTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [POS_W-1:0]                  req_position,
   input  logic signed [VALUE_WIDTH-1:0]     req_new_value,
   input  logic [POS_W-1:0]                  req_range_low,
   input  logic [POS_W-1:0]                  req_range_high,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]     rsp_range_sum,

   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rss_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rss_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rss_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   // Tree geometry: leaves sit at node index 2^POS_W + position.
   localparam int ADDR_W = POS_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int IDX_W  = ADDR_W + 1;

   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_UP_READ = 5'b00100,
      ST_UP_ADD  = 5'b01000,
      ST_Q_LOOP  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      node_ff, node_in;
   logic [IDX_W-1:0]       lo_ff, lo_in;
   logic [IDX_W-1:0]       hi_ff, hi_in;
   logic [IDX_W-1:0]       hi_dec;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   leaf_ff, leaf_in;
   logic                   pend_ff, pend_in;
   logic [LEN_W-1:0]       used_length_ff, used_length_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_range_sum_ff;

   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [VALUE_WIDTH-1:0] ram_wdata;
   logic [ADDR_W-1:0]      ram_raddr;
   logic [VALUE_WIDTH-1:0] ram_rdata;

   rss_pkg::alu_op_type    alu_op;
   logic [VALUE_WIDTH-1:0] alu_a;
   logic [VALUE_WIDTH-1:0] alu_b;
   logic [VALUE_WIDTH-1:0] alu_y;

   logic                   csr_wr;
   logic [LEN_W-1:0]       len_wr;
   logic [LEN_W-1:0]       len_m1;
   logic [POS_W-1:0]       hi_clip;
   logic                   range_empty;
   logic                   set_in_range;
   logic                   out_free;
   logic                   rsp_load;

   // Node sums and leaf values share one RAM.
   rss_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_rss_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rss_alu #(
      .WIDTH (VALUE_WIDTH)
   ) u_rss_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   // Register port: a write clamps the length into 1..MAX_LENGTH.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready &&
                   (paddr[rss_pkg::CSR_ADDR_W-1:2] == rss_pkg::REG_USED_LENGTH);
   assign prdata = rss_pkg::CSR_DATA_W'(used_length_ff);

   always_comb begin
      if (pwdata == '0) begin
         len_wr = LEN_W'(1);
      end else if (pwdata > rss_pkg::CSR_DATA_W'(MAX_LENGTH)) begin
         len_wr = LEN_W'(MAX_LENGTH);
      end else begin
         len_wr = pwdata[LEN_W-1:0];
      end
   end

   assign used_length_in = csr_wr ? len_wr : used_length_ff;

   // Request decode: clip the query to the used positions.
   assign len_m1       = used_length_ff - LEN_W'(1);
   assign hi_clip      = (LEN_W'(req_range_high) >= used_length_ff) ?
                         len_m1[POS_W-1:0] : req_range_high;
   assign range_empty  = (req_range_low > hi_clip);
   assign set_in_range = (LEN_W'(req_position) < used_length_ff);
   assign hi_dec       = hi_ff - IDX_W'(1);

   // Output register frees when empty or when its transaction is taken.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      node_in   = node_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      acc_in    = acc_ff;
      val_in    = val_ff;
      leaf_in   = leaf_ff;
      pend_in   = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = node_ff;
      ram_wdata = '0;
      ram_raddr = node_ff;
      alu_op    = rss_pkg::ALU_ADD;
      alu_a     = acc_ff;
      alu_b     = pend_ff ? ram_rdata : '0;
      rsp_load  = 1'b0;

      case (state_ff)
         // Sweep every node to zero after reset.
         ST_CLEAR: begin
            ram_we  = 1'b1;
            node_in = node_ff + ADDR_W'(1);
            if (node_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == rss_pkg::KIND_SET) begin
                  // A set beyond the used length is dropped.
                  if (set_in_range) begin
                     node_in  = {1'b1, req_position};
                     val_in   = req_new_value;
                     leaf_in  = 1'b1;
                     state_in = ST_UP_READ;
                  end
               end else begin
                  acc_in   = '0;
                  state_in = ST_Q_LOOP;
                  // An empty range starts with no nodes left to visit.
                  if (range_empty) begin
                     lo_in = '0;
                     hi_in = '0;
                  end else begin
                     lo_in = {2'b01, req_range_low};
                     hi_in = {2'b01, hi_clip} + IDX_W'(1);
                  end
               end
            end
         end

         ST_UP_READ: begin
            state_in = ST_UP_ADD;
         end

         // The leaf step forms the difference and stores the new value;
         // every level above adds that difference.
         ST_UP_ADD: begin
            alu_b  = ram_rdata;
            ram_we = 1'b1;
            if (leaf_ff) begin
               alu_op    = rss_pkg::ALU_SUB;
               alu_a     = val_ff;
               acc_in    = alu_y;
               ram_wdata = val_ff;
            end else begin
               ram_wdata = alu_y;
            end
            leaf_in = 1'b0;
            if (node_ff == ADDR_W'(1)) begin
               state_in = ST_IDLE;
            end else begin
               node_in  = node_ff >> 1;
               state_in = ST_UP_READ;
            end
         end

         // Bottom-up walk over the half-open index range [lo, hi): each
         // cycle issues one node read or climbs one level, while the read
         // issued in the previous cycle is added in.
         ST_Q_LOOP: begin
            acc_in = alu_y;
            if (lo_ff < hi_ff) begin
               if (lo_ff[0]) begin
                  ram_raddr = lo_ff[ADDR_W-1:0];
                  lo_in     = lo_ff + IDX_W'(1);
                  pend_in   = 1'b1;
               end else if (hi_ff[0]) begin
                  ram_raddr = hi_dec[ADDR_W-1:0];
                  hi_in     = hi_dec;
                  pend_in   = 1'b1;
               end else begin
                  lo_in = lo_ff >> 1;
                  hi_in = hi_ff >> 1;
               end
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: loaded by a finished query, dropped when taken.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         node_ff        <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         used_length_ff <= LEN_W'(MAX_LENGTH);
      end else begin
         state_ff       <= state_in;
         node_ff        <= node_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         used_length_ff <= used_length_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      acc_ff  <= acc_in;
      val_ff  <= val_in;
      leaf_ff <= leaf_in;
      if (rsp_load) begin
         rsp_range_sum_ff <= alu_y;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_range_sum_ff;

endmodule

`default_nettype wire

FILE: rtl/rss_checker.sv
// ----------------------------------------------------------------------------
// Range-sum segment tree port checker
// Watches the top level's channels over time and flags sequencing faults.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_checker #(
   parameter int VALUE_WIDTH = rss_pkg::DEF_VALUE_WIDTH
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   req_kind,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [VALUE_WIDTH-1:0] rsp_range_sum
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // The clearing pass holds off requests right after reset.
   a_stall_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request channel open right after reset");

   // A set transaction never produces a result.
   a_set_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_kind == rss_pkg::KIND_SET && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared for a set transaction");

   // Every query keeps the block busy for at least the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_kind == rss_pkg::KIND_QUERY && !rsp_valid) |=>
      (req_stall && !rsp_valid))
      else $error("block not busy after taking a query");

   // A new result is only produced while a query is being worked on.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

   // A stalled result stays and holds its value.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_range_sum)))
      else $error("stalled result changed or was dropped");

endmodule

bind range_sum_segment_tree_unit rss_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_rss_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_kind      (req_kind),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_range_sum (rsp_range_sum)
);

`default_nettype wire

FILE: dv/range_sum_segment_tree_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range-sum segment tree unit testbench
// Sends point assignments and range sum queries with random gaps and random
// response stalls. A shadow copy of the position values gives the expected
// wrapped sum of every query, and each returned sum is checked in order. The
// used length is rewritten between phases, including out-of-range values.
// ----------------------------------------------------------------------------

module range_sum_segment_tree_unit_tb;

   localparam int MAX_LEN         = rss_pkg::DEF_MAX_LENGTH;
   localparam int VAL_W           = rss_pkg::DEF_VALUE_WIDTH;
   localparam int POS_W           = $clog2(MAX_LEN);
   localparam int SETTLE_CYCLES   = 200;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int PHASE_ITEMS     = 172;
   localparam int PRESSURE_PHASE  = 3;
   localparam int HOLD_OFF_CYCLES = 800;

   // One request transaction plus the idle cycles that precede it.
   typedef struct {
      logic                    kind;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] new_value;
      logic [POS_W-1:0]        range_low;
      logic [POS_W-1:0]        range_high;
      int unsigned             gap;
   } req_item_type;

   // Expected sum of one accepted query.
   typedef struct {
      logic signed [VAL_W-1:0] sum;
      logic [POS_W-1:0]        lo;
      logic [POS_W-1:0]        hi;
   } range_sum_due_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid      = 1'b0;
   logic                    req_stall;
   logic                    req_kind       = rss_pkg::KIND_SET;
   logic [POS_W-1:0]        req_position   = '0;
   logic signed [VAL_W-1:0] req_new_value  = '0;
   logic [POS_W-1:0]        req_range_low  = '0;
   logic [POS_W-1:0]        req_range_high = '0;

   logic                    rsp_valid;
   logic                    rsp_stall      = 1'b0;
   logic signed [VAL_W-1:0] rsp_range_sum;

   logic                             psel    = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite  = 1'b0;
   logic [rss_pkg::CSR_ADDR_W-1:0]   paddr   = '0;
   logic [rss_pkg::CSR_DATA_W-1:0]   pwdata  = '0;
   logic [rss_pkg::CSR_DATA_W-1:0]   prdata;
   logic                             pready;

   // Shadow state of the block.
   logic [VAL_W-1:0]        leaf_store [MAX_LEN];
   int unsigned             used_len = MAX_LEN;

   req_item_type            pending_reqs [$];
   range_sum_due_type       sums_due [$];

   req_item_type            next_req;
   bit                      req_loaded    = 1'b0;
   int unsigned             req_gap_left  = 0;
   bit                      req_taken     = 1'b0;
   bit                      rsp_taken     = 1'b0;
   int unsigned             rsp_wait      = 0;
   int unsigned             hold_off_left = 0;
   bit                      req_idle_on   = 1'b1;
   bit                      rsp_idle_on   = 1'b1;
   int unsigned             error_count   = 0;
   int unsigned             cycle_count   = 0;

   range_sum_segment_tree_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_new_value  (req_new_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_range_sum  (rsp_range_sum),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #5 clock = ~clock;

   // One line per mismatch, and every mismatch is counted.
   task automatic report_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Wrapped total of the stored values over [lo, hi], clipped at the used length.
   function automatic logic [VAL_W-1:0] range_total(input int unsigned lo,
                                                   input int unsigned hi);
      logic [VAL_W-1:0] acc;
      int unsigned      top;
      acc = '0;
      if (lo > hi) return acc;
      top = (hi < used_len) ? hi : used_len - 1;
      for (int unsigned p = lo; p <= top; p++) begin
         acc += leaf_store[p];
      end
      return acc;
   endfunction

   // Apply one accepted transaction to the shadow state.
   function automatic void apply_request(input logic kind, input int unsigned pos,
                                         input logic [VAL_W-1:0] value,
                                         input logic [POS_W-1:0] lo,
                                         input logic [POS_W-1:0] hi);
      range_sum_due_type due;
      if (kind == rss_pkg::KIND_SET) begin
         // Sets beyond the used length are dropped.
         if (pos < used_len) leaf_store[pos] = value;
      end else begin
         due.sum = range_total(32'(lo), 32'(hi));
         due.lo  = lo;
         due.hi  = hi;
         sums_due.push_back(due);
      end
   endfunction

   function automatic req_item_type set_item(input int unsigned pos,
                                             input logic [VAL_W-1:0] value);
      req_item_type it;
      it.kind       = rss_pkg::KIND_SET;
      it.position   = POS_W'(pos);
      it.new_value  = value;
      it.range_low  = POS_W'($urandom);
      it.range_high = POS_W'($urandom);
      it.gap        = 0;
      return it;
   endfunction

   function automatic req_item_type query_item(input int unsigned lo,
                                               input int unsigned hi);
      req_item_type it;
      it.kind       = rss_pkg::KIND_QUERY;
      it.position   = POS_W'($urandom);
      it.new_value  = $urandom;
      it.range_low  = POS_W'(lo);
      it.range_high = POS_W'(hi);
      it.gap        = 0;
      return it;
   endfunction

   // Random transaction for a given used length.
   function automatic req_item_type draw_item(input int unsigned len);
      req_item_type it;
      int unsigned  pick;
      int unsigned  a;
      int unsigned  b;
      if ($urandom_range(0, 1) == 0) begin
         it = set_item($urandom, $urandom);
         // Mostly in-range positions, sometimes anywhere in the field.
         if ($urandom_range(0, 9) != 0) it.position = POS_W'($urandom_range(0, len - 1));
         pick = $urandom_range(0, 9);
         case (pick)
            0: it.new_value = 32'h7fff_ffff;
            1: it.new_value = 32'h8000_0000;
            2: it.new_value = '0;
            3: it.new_value = '1;
            default: ;
         endcase
      end else begin
         it = query_item($urandom, $urandom);
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               it.range_low  = '0;
               it.range_high = POS_W'(len - 1);
            end
            1: begin
               it.range_low  = '0;
               it.range_high = POS_W'(MAX_LEN - 1);
            end
            2: begin
               a             = $urandom_range(0, len - 1);
               it.range_low  = POS_W'(a);
               it.range_high = POS_W'(a);
            end
            3: begin
               a             = $urandom_range(1, MAX_LEN - 1);
               it.range_low  = POS_W'(a);
               it.range_high = POS_W'($urandom_range(0, a - 1));
            end
            4, 5: ;
            default: begin
               a             = $urandom_range(0, len - 1);
               b             = $urandom_range(0, len - 1);
               it.range_low  = POS_W'((a < b) ? a : b);
               it.range_high = POS_W'((a < b) ? b : a);
            end
         endcase
      end
      return it;
   endfunction

   task automatic queue_item(input req_item_type it);
      it.gap = req_idle_on ? $urandom_range(0, 5) : 0;
      pending_reqs.push_back(it);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_used_length(input int unsigned value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {rss_pkg::REG_USED_LENGTH, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // Out-of-range lengths saturate; stored values are kept across the change.
      if (value < 1) used_len = 1;
      else if (value > MAX_LEN) used_len = MAX_LEN;
      else used_len = value;
      @(posedge clock);
   endtask

   // Wait until all transactions are sent and all sums are back.
   task automatic wait_quiet();
      while (pending_reqs.size() != 0 || req_loaded || req_valid || sums_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: holds a transaction until taken, then inserts the next one's gap.
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (!req_loaded && pending_reqs.size() != 0) begin
            next_req     = pending_reqs.pop_front();
            req_loaded   = 1'b1;
            req_gap_left = next_req.gap;
         end
         if (req_loaded && req_gap_left == 0) begin
            req_valid      <= 1'b1;
            req_kind       <= next_req.kind;
            req_position   <= next_req.position;
            req_new_value  <= next_req.new_value;
            req_range_low  <= next_req.range_low;
            req_range_high <= next_req.range_high;
            req_loaded     = 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (req_loaded) req_gap_left--;
         end
      end
   end

   // Response receiver: random stalls per transaction plus one long hold-off.
   always @(negedge clock) begin
      if (rsp_taken) rsp_wait = rsp_idle_on ? $urandom_range(0, 5) : 0;
      if (hold_off_left != 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else if (rsp_wait != 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: checks returned sums, then folds accepted requests into the shadow.
   always @(posedge clock) begin
      range_sum_due_type due;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            if (sums_due.size() == 0) begin
               report_mismatch($sformatf("unexpected range_sum %0d", rsp_range_sum));
            end else begin
               due = sums_due.pop_front();
               if (rsp_range_sum !== due.sum) begin
                  report_mismatch($sformatf("range_sum [%0d:%0d] got %0d expected %0d",
                                            due.lo, due.hi, rsp_range_sum, due.sum));
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            apply_request(req_kind, 32'(req_position), req_new_value, req_range_low,
                          req_range_high);
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Stimulus sequence.
   initial begin
      int unsigned lens [10];
      lens = '{1, 2, 3, 100, 17, 513, 1000, 1024, 2047, 0};
      lens[4] = $urandom_range(4, MAX_LEN - 1);
      foreach (leaf_store[i]) leaf_store[i] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed checks at the reset length: extremes, overwrite and wrap.
      queue_item(set_item(0, 32'h7fff_ffff));
      queue_item(set_item(MAX_LEN - 1, 32'h8000_0000));
      queue_item(set_item(511, 32'hffff_ffff));
      queue_item(set_item(512, 32'h0000_0001));
      queue_item(query_item(0, MAX_LEN - 1));
      queue_item(query_item(0, 0));
      queue_item(query_item(MAX_LEN - 1, MAX_LEN - 1));
      queue_item(query_item(511, 512));
      queue_item(query_item(5, 4));
      queue_item(set_item(1, 32'h7fff_ffff));
      queue_item(query_item(0, 1));
      queue_item(set_item(0, 32'h0000_0000));
      queue_item(query_item(0, 1));
      wait_quiet();

      // Short length: sets past the end are ignored and ranges are clipped.
      write_used_length(7);
      queue_item(set_item(9, 32'd12345));
      queue_item(set_item(6, -32'sd7));
      queue_item(query_item(0, MAX_LEN - 1));
      queue_item(query_item(6, 6));
      queue_item(query_item(7, MAX_LEN - 1));
      wait_quiet();

      // A length of zero behaves as one.
      write_used_length(0);
      queue_item(query_item(0, MAX_LEN - 1));
      queue_item(set_item(0, 32'h8000_0000));
      queue_item(query_item(0, 0));
      wait_quiet();

      // An oversized length saturates, and values beyond the old length come back.
      write_used_length(2047);
      queue_item(query_item(0, MAX_LEN - 1));
      queue_item(query_item(1000, MAX_LEN - 1));

      // Random phases, one used length each.
      foreach (lens[k]) begin
         wait_quiet();
         write_used_length(lens[k]);
         req_idle_on = (k % 3 != 1) && (k != PRESSURE_PHASE);
         rsp_idle_on = (k % 3 != 2);
         // Hold the output back while requests keep coming, to back up the input.
         if (k == PRESSURE_PHASE) hold_off_left = HOLD_OFF_CYCLES;
         for (int n = 0; n < PHASE_ITEMS; n++) queue_item(draw_item(used_len));
      end
      wait_quiet();

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
